// ----- design/fmag_pkg.sv -----
// fmag_pkg: shared types, constants and functions of the magnitude spectrum block
// holds the cosine table, twiddle rounding and bit-reversal helpers
// no dependencies
package fmag_pkg;

    localparam int SAMPLE_W = 16;
    localparam int DATA_W   = 24;
    localparam int MAG_W    = 22;
    localparam int BIN_W    = 6;
    localparam int LG_W     = 3;
    localparam int CNT_W    = 7;
    localparam int IDX_W    = 6;
    localparam int ROOT_W   = 24;
    localparam int SQ_W     = 2 * DATA_W;

    // write request to the work buffer
    typedef struct packed {
        logic                  we;
        logic [IDX_W-1:0]      addr;
        logic [2*DATA_W-1:0]   data;
    } t_ram_wr;

    // one result word
    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic [BIN_W-1:0] bin_index;
        logic             last_bin;
    } t_result;

    // complex twiddle factor
    typedef struct packed {
        logic signed [DATA_W-1:0] wr;
        logic signed [DATA_W-1:0] wi;
    } t_tw;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SW_RA,
        BK_SW_RB,
        BK_SW_CAP,
        BK_SW_WA,
        BK_SW_WB,
        BK_BF_RA,
        BK_BF_RC,
        BK_BF_CAP,
        BK_BF_MUL,
        BK_BF_WA,
        BK_BF_WC,
        BK_MG_RD,
        BK_MG_CAP,
        BK_MG_SQ,
        BK_MG_ROOT
    } t_back_state;

    // cos(2*pi*k/64) in Q1.22, quarter wave
    function automatic logic [22:0] cos_q22(input logic [4:0] k);
        logic [22:0] v;
        case (k)
            5'd0:    v = 23'd4194304;
            5'd1:    v = 23'd4174107;
            5'd2:    v = 23'd4113712;
            5'd3:    v = 23'd4013699;
            5'd4:    v = 23'd3875032;
            5'd5:    v = 23'd3699046;
            5'd6:    v = 23'd3487436;
            5'd7:    v = 23'd3242241;
            5'd8:    v = 23'd2965821;
            5'd9:    v = 23'd2660838;
            5'd10:   v = 23'd2330230;
            5'd11:   v = 23'd1977181;
            5'd12:   v = 23'd1605091;
            5'd13:   v = 23'd1217542;
            5'd14:   v = 23'd818268;
            5'd15:   v = 23'd411114;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

    // table entry rounded half away from zero to f fraction bits
    function automatic logic [22:0] tw_abs(input logic [4:0] k, input int f);
        logic [23:0] v;
        v = {1'b0, cos_q22(k)};
        if (f < 22) begin
            v = (v + 24'(1 << (21 - f))) >> (22 - f);
        end
        return v[22:0];
    endfunction

    // w = cos - i sin of 2*pi*t/64
    function automatic t_tw twiddle(input logic [4:0] t, input int f);
        t_tw w;
        if (t <= 5'd16) begin
            w.wr = $signed({1'b0, tw_abs(t, f)});
            w.wi = -$signed({1'b0, tw_abs(5'd16 - t, f)});
        end else begin
            w.wr = -$signed({1'b0, tw_abs(5'd0 - t, f)});
            w.wi = -$signed({1'b0, tw_abs(t - 5'd16, f)});
        end
        return w;
    endfunction

    // reverse the low lg bits of an index
    function automatic logic [IDX_W-1:0] bitrev(input logic [IDX_W-1:0] i,
                                                input logic [LG_W-1:0] lg);
        logic [IDX_W-1:0] r;
        for (int b = 0; b < IDX_W; b++) begin
            r[b] = i[IDX_W-1-b];
        end
        return r >> (3'd6 - lg);
    endfunction

endpackage

// ----- design/fmag_ram.sv -----
// fmag_ram: generic single write, single read memory with registered read data
// no dependencies
module fmag_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/fmag_fifo.sv -----
// fmag_fifo: small first-in first-out queue of register slots
// no dependencies
module fmag_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (32'(r_wr_ptr) == DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (32'(r_rd_ptr) == DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // payload slots
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_wdata;
        end
    end

    assign o_rdata = r_slot[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (32'(r_count) == DEPTH);

endmodule

// ----- design/fmag_front.sv -----
// fmag_front: size register, sample loading and frame completion detection
// depends on fmag_pkg
module fmag_front
    import fmag_pkg::*;
#(
    parameter int MAX_LG = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [LG_W-1:0]     i_cfg_wdata,
    input  logic                i_accept,
    input  logic [SAMPLE_W-1:0] i_sample,
    output t_ram_wr             o_wr,
    output logic                o_job_push,
    output logic [LG_W-1:0]     o_job_lg
);

    logic [LG_W-1:0]  r_size_log2;
    logic [CNT_W-1:0] r_count, n_count;
    logic [LG_W-1:0]  lg_eff;
    logic [CNT_W-1:0] frame_n;
    logic [CNT_W-1:0] count_inc;
    logic             frame_done;

    // frame length in use, clamped to the buffer size
    assign lg_eff     = (r_size_log2 > LG_W'(MAX_LG)) ? LG_W'(MAX_LG) : r_size_log2;
    assign frame_n    = CNT_W'(1) << lg_eff;
    assign count_inc  = r_count + 1'b1;
    assign frame_done = (count_inc >= frame_n);

    // sample count
    always_comb begin
        n_count = r_count;
        if (i_accept) begin
            n_count = frame_done ? '0 : count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2 <= LG_W'(6);
            r_count     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_size_log2 <= i_cfg_wdata;
            end
            r_count <= n_count;
        end
    end

    // store sample as a real word
    assign o_wr.we   = i_accept;
    assign o_wr.addr = r_count[IDX_W-1:0];
    assign o_wr.data = {{(DATA_W-SAMPLE_W){i_sample[SAMPLE_W-1]}}, i_sample,
                        {DATA_W{1'b0}}};

    assign o_job_push = i_accept && frame_done;
    assign o_job_lg   = lg_eff;

endmodule

// ----- design/fmag_isqrt.sv -----
// fmag_isqrt: floor square root, one result bit per cycle
// depends on fmag_pkg
module fmag_isqrt
    import fmag_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SQ_W-1:0]   i_value,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [4:0]        r_cnt, n_cnt;
    logic [SQ_W-1:0]   r_x, n_x;
    logic [ROOT_W+1:0] r_rem, n_rem;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [ROOT_W+3:0] rem_sh;
    logic [ROOT_W+3:0] trial;

    assign rem_sh = {r_rem, r_x[SQ_W-1 -: 2]};
    assign trial  = {2'b00, r_root, 2'b01};

    // restoring step on two input bits
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_rem  = r_rem;
        n_root = r_root;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_x    = i_value;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_x = {r_x[SQ_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                n_rem  = (ROOT_W+2)'(rem_sh - trial);
                n_root = {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh[ROOT_W+1:0];
                n_root = {r_root[ROOT_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == 5'(ROOT_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ----- design/fmag_back.sv -----
// fmag_back: transform sequencer with one shared multiplier, then bin magnitudes
// depends on fmag_pkg and fmag_isqrt
module fmag_back
    import fmag_pkg::*;
#(
    parameter int TWIDDLE_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  logic [LG_W-1:0]     i_job_lg,
    output logic                o_job_pop,
    output t_ram_wr             o_wr,
    output logic [IDX_W-1:0]    o_raddr,
    input  logic [2*DATA_W-1:0] i_rdata,
    output logic                o_res_push,
    output t_result             o_res,
    input  logic                i_res_full,
    output logic                o_busy
);

    localparam int FRAC = (TWIDDLE_BITS - 2 > 22) ? 22 :
                          (TWIDDLE_BITS - 2 < 1) ? 1 : TWIDDLE_BITS - 2;
    localparam logic [SQ_W:0] RND = (SQ_W+1)'(1) << (FRAC - 1);

    t_back_state r_state, n_state;
    logic [LG_W-1:0]          r_lg, n_lg;
    logic [CNT_W-1:0]         r_i, n_i;
    logic [LG_W-1:0]          r_stage, n_stage;
    logic [IDX_W-1:0]         r_bf, n_bf;
    logic [BIN_W-1:0]         r_k, n_k;
    logic [2:0]               r_step, n_step;
    logic [2*DATA_W-1:0]      r_u, n_u;
    logic [2*DATA_W-1:0]      r_b, n_b;
    t_tw                      r_tw, n_tw;
    logic signed [SQ_W-1:0]   r_prod, n_prod;
    logic signed [SQ_W-1:0]   r_acc, n_acc;
    logic [DATA_W-1:0]        r_vr, n_vr;
    logic [DATA_W-1:0]        r_vi, n_vi;

    logic [CNT_W-1:0]         frame_n;
    logic [IDX_W-1:0]         half_n;
    logic [IDX_W-1:0]         rev;
    logic [IDX_W-1:0]         j_idx, half_bit, a_idx, c_idx;
    logic [IDX_W-1:0]         t_full;
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [SQ_W:0]     bf_sum;
    logic [SQ_W-1:0]          sq_sum;
    logic                     sq_start, sq_done;
    logic [ROOT_W-1:0]        sq_root;

    assign frame_n = CNT_W'(1) << r_lg;
    assign half_n  = frame_n[IDX_W:1];
    assign rev     = bitrev(r_i[IDX_W-1:0], r_lg);

    // butterfly addresses for the current stage
    assign half_bit = IDX_W'(1) << (r_stage - 1'b1);
    assign j_idx    = r_bf & (half_bit - 1'b1);
    assign a_idx    = ((r_bf >> (r_stage - 1'b1)) << r_stage) | j_idx;
    assign c_idx    = a_idx | half_bit;
    assign t_full   = j_idx << (3'd6 - r_stage);

    // shared multiplier operand selection
    always_comb begin
        mul_a = $signed(r_b[2*DATA_W-1:DATA_W]);
        mul_b = r_tw.wr;
        if (r_state == BK_BF_MUL) begin
            case (r_step)
                3'd0:    begin mul_a = $signed(r_b[2*DATA_W-1:DATA_W]); mul_b = r_tw.wr; end
                3'd1:    begin mul_a = $signed(r_b[DATA_W-1:0]);        mul_b = r_tw.wi; end
                3'd2:    begin mul_a = $signed(r_b[2*DATA_W-1:DATA_W]); mul_b = r_tw.wi; end
                default: begin mul_a = $signed(r_b[DATA_W-1:0]);        mul_b = r_tw.wr; end
            endcase
        end else if (r_step == 3'd0) begin
            mul_a = $signed(r_b[2*DATA_W-1:DATA_W]);
            mul_b = $signed(r_b[2*DATA_W-1:DATA_W]);
        end else begin
            mul_a = $signed(r_b[DATA_W-1:0]);
            mul_b = $signed(r_b[DATA_W-1:0]);
        end
    end

    // rounded product sum, difference on the real part
    always_comb begin
        if (r_step == 3'd2) begin
            bf_sum = $signed({r_acc[SQ_W-1], r_acc}) - $signed({r_prod[SQ_W-1], r_prod})
                     + $signed(RND);
        end else begin
            bf_sum = $signed({r_acc[SQ_W-1], r_acc}) + $signed({r_prod[SQ_W-1], r_prod})
                     + $signed(RND);
        end
    end

    assign sq_sum = $unsigned(r_acc) + $unsigned(r_prod);

    // sequencer: next state, datapath registers and ports
    always_comb begin
        n_state    = r_state;
        n_lg       = r_lg;
        n_i        = r_i;
        n_stage    = r_stage;
        n_bf       = r_bf;
        n_k        = r_k;
        n_step     = r_step;
        n_u        = r_u;
        n_b        = r_b;
        n_tw       = r_tw;
        n_prod     = r_prod;
        n_acc      = r_acc;
        n_vr       = r_vr;
        n_vi       = r_vi;
        o_job_pop  = 1'b0;
        o_wr       = '0;
        o_raddr    = '0;
        o_res_push = 1'b0;
        sq_start   = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_lg      = i_job_lg;
                    n_i       = '0;
                    n_state   = BK_SW_RA;
                end
            end
            // bit-reversal reordering
            BK_SW_RA: begin
                if (r_i[IDX_W-1:0] < rev) begin
                    o_raddr = r_i[IDX_W-1:0];
                    n_state = BK_SW_RB;
                end else if (r_i + 1'b1 == frame_n) begin
                    n_stage = LG_W'(1);
                    n_bf    = '0;
                    n_k     = '0;
                    n_state = (r_lg == '0) ? BK_MG_RD : BK_BF_RA;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            BK_SW_RB: begin
                o_raddr = rev;
                n_u     = i_rdata;
                n_state = BK_SW_CAP;
            end
            BK_SW_CAP: begin
                n_b     = i_rdata;
                n_state = BK_SW_WA;
            end
            BK_SW_WA: begin
                o_wr    = '{we: 1'b1, addr: r_i[IDX_W-1:0], data: r_b};
                n_state = BK_SW_WB;
            end
            BK_SW_WB: begin
                o_wr = '{we: 1'b1, addr: rev, data: r_u};
                if (r_i + 1'b1 == frame_n) begin
                    n_stage = LG_W'(1);
                    n_bf    = '0;
                    n_k     = '0;
                    n_state = (r_lg == '0) ? BK_MG_RD : BK_BF_RA;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = BK_SW_RA;
                end
            end
            // butterflies
            BK_BF_RA: begin
                o_raddr = a_idx;
                n_tw    = twiddle(t_full[4:0], FRAC);
                n_state = BK_BF_RC;
            end
            BK_BF_RC: begin
                o_raddr = c_idx;
                n_u     = i_rdata;
                n_state = BK_BF_CAP;
            end
            BK_BF_CAP: begin
                n_b     = i_rdata;
                n_step  = '0;
                n_state = BK_BF_MUL;
            end
            BK_BF_MUL: begin
                n_prod = mul_a * mul_b;
                n_step = r_step + 1'b1;
                case (r_step)
                    3'd1, 3'd3: n_acc = r_prod;
                    3'd2:       n_vr  = bf_sum[FRAC+DATA_W-1:FRAC];
                    3'd4: begin
                        n_vi    = bf_sum[FRAC+DATA_W-1:FRAC];
                        n_state = BK_BF_WA;
                    end
                    default: ;
                endcase
            end
            BK_BF_WA: begin
                o_wr = '{we: 1'b1, addr: a_idx,
                         data: {r_u[2*DATA_W-1:DATA_W] + r_vr, r_u[DATA_W-1:0] + r_vi}};
                n_state = BK_BF_WC;
            end
            BK_BF_WC: begin
                o_wr = '{we: 1'b1, addr: c_idx,
                         data: {r_u[2*DATA_W-1:DATA_W] - r_vr, r_u[DATA_W-1:0] - r_vi}};
                if (r_bf + 1'b1 == half_n) begin
                    n_bf = '0;
                    if (r_stage == r_lg) begin
                        n_k     = '0;
                        n_state = BK_MG_RD;
                    end else begin
                        n_stage = r_stage + 1'b1;
                        n_state = BK_BF_RA;
                    end
                end else begin
                    n_bf    = r_bf + 1'b1;
                    n_state = BK_BF_RA;
                end
            end
            // bin magnitudes
            BK_MG_RD: begin
                o_raddr = r_k;
                n_state = BK_MG_CAP;
            end
            BK_MG_CAP: begin
                n_b     = i_rdata;
                n_step  = '0;
                n_state = BK_MG_SQ;
            end
            BK_MG_SQ: begin
                n_prod = mul_a * mul_b;
                n_step = r_step + 1'b1;
                if (r_step == 3'd1) begin
                    n_acc = r_prod;
                end else if (r_step == 3'd2) begin
                    sq_start = 1'b1;
                    n_state  = BK_MG_ROOT;
                end
            end
            BK_MG_ROOT: begin
                if (sq_done) begin
                    n_step = 3'd7;
                end
                if ((sq_done || r_step == 3'd7) && !i_res_full) begin
                    o_res_push = 1'b1;
                    if (r_k == half_n) begin
                        n_state = BK_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = BK_MG_RD;
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_lg    <= '0;
            r_i     <= '0;
            r_stage <= '0;
            r_bf    <= '0;
            r_k     <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_lg    <= n_lg;
            r_i     <= n_i;
            r_stage <= n_stage;
            r_bf    <= n_bf;
            r_k     <= n_k;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u    <= n_u;
        r_b    <= n_b;
        r_tw   <= n_tw;
        r_prod <= n_prod;
        r_acc  <= n_acc;
        r_vr   <= n_vr;
        r_vi   <= n_vi;
    end

    fmag_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (sq_sum),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // result word, magnitude saturated to the port width
    assign o_res.magnitude = (|sq_root[ROOT_W-1:MAG_W]) ? '1 : sq_root[MAG_W-1:0];
    assign o_res.bin_index = r_k;
    assign o_res.last_bin  = (r_k == half_n);

    assign o_busy = (r_state != BK_IDLE);

endmodule

// ----- design/fft_magnitude_spectrum_top.sv -----
// fft_magnitude_spectrum_top: radix-2 FFT magnitude spectrum of real sample frames
// depends on fmag_pkg, fmag_ram, fmag_fifo, fmag_front, fmag_back
//
// channel  | direction | handshake         | word
// ---------+-----------+-------------------+-----------------------------------
// sample   | in        | push / full       | i_sample
// result   | out       | empty / pop       | o_magnitude, o_bin_index, o_last_bin
// config   | in        | i_cfg_we          | i_cfg_wdata (size_log2)
//
// samples load at one per cycle while full is low; full rises after the last sample of a
// frame and stays high until its bins have all been handed to the output queue
// per frame of N: bit-reversal reorder, then butterflies (one shared multiplier, single-port
// buffer reads), then one magnitude per bin (24-step square root)
// synchronous reset clears control, size_log2 returns to 6; a stalled pop holds the back end
module fft_magnitude_spectrum_top
    import fmag_pkg::*;
#(
    parameter int MAX_POINTS   = 64,
    parameter int TWIDDLE_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                empty,
    input  logic                pop,
    output logic [MAG_W-1:0]    o_magnitude,
    output logic [BIN_W-1:0]    o_bin_index,
    output logic                o_last_bin,
    input  logic                i_cfg_we,
    input  logic [LG_W-1:0]     i_cfg_wdata
);

    localparam int MAX_LG = ($clog2(MAX_POINTS + 1) - 1 > 6) ? 6 :
                            $clog2(MAX_POINTS + 1) - 1;
    localparam int DEPTH  = 1 << MAX_LG;
    localparam int RES_W  = MAG_W + BIN_W + 1;

    logic             accept;
    t_ram_wr          front_wr, back_wr, ram_wr;
    logic             job_push, job_pop, job_empty, job_full;
    logic [LG_W-1:0]  job_lg_in, job_lg_out;
    logic [IDX_W-1:0] back_raddr;
    logic [2*DATA_W-1:0] ram_rdata;
    logic             back_busy;
    logic             res_push, res_full;
    t_result          res_in, res_out;

    // input taken only while no frame is pending or in progress
    assign full   = !job_empty || back_busy;
    assign accept = push && !full;

    fmag_front #(
        .MAX_LG (MAX_LG)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_sample    (i_sample),
        .o_wr        (front_wr),
        .o_job_push  (job_push),
        .o_job_lg    (job_lg_in)
    );

    // frame requests between front and back
    fmag_fifo #(
        .WIDTH (LG_W),
        .DEPTH (2)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_wdata (job_lg_in),
        .i_pop   (job_pop),
        .o_rdata (job_lg_out),
        .o_empty (job_empty),
        .o_full  (job_full)
    );

    fmag_back #(
        .TWIDDLE_BITS (TWIDDLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!job_empty),
        .i_job_lg    (job_lg_out),
        .o_job_pop   (job_pop),
        .o_wr        (back_wr),
        .o_raddr     (back_raddr),
        .i_rdata     (ram_rdata),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_full  (res_full),
        .o_busy      (back_busy)
    );

    // work buffer write port owned by the back end while it runs
    assign ram_wr = back_busy ? back_wr : front_wr;

    fmag_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (DEPTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_wr.we),
        .i_waddr (ram_wr.addr[MAX_LG-1:0]),
        .i_wdata (ram_wr.data),
        .i_raddr (back_raddr[MAX_LG-1:0]),
        .o_rdata (ram_rdata)
    );

    // result queue
    fmag_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res_in),
        .i_pop   (pop),
        .o_rdata (res_out),
        .o_empty (empty),
        .o_full  (res_full)
    );

    assign o_magnitude = res_out.magnitude;
    assign o_bin_index = res_out.bin_index;
    assign o_last_bin  = res_out.last_bin;

    // buffer never written by both sides
    a_front_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_wr.we |-> !back_busy)
        else $error("sample write while transform runs");

    // at most one frame request outstanding
    a_one_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_push |-> (job_empty && !job_full))
        else $error("frame request queued behind another");

    // results never dropped at the queue
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");

endmodule
